// ===== rtl/i2cra_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cra_pkg
// Shared types, codes and sequence tables for the I2C register access master.
// ----------------------------------------------------------------------------
package i2cra_pkg;

  // width of the per-phase tick counter
  localparam int PHASE_COUNT_BITS = 10;
  // compare width: holds 2^PHASE_COUNT_BITS and the 10-bit register
  localparam int CMP_W = ((PHASE_COUNT_BITS > 10) ? PHASE_COUNT_BITS : 10) + 1;

  // command codes carried in s_tuser
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // configuration register indexes
  localparam logic CFG_DEV_ADDR    = 1'b0;
  localparam logic CFG_PHASE_TICKS = 1'b1;

  // reset values of the configuration registers
  localparam logic [6:0] DEV_ADDR_RESET    = 7'd127;
  localparam logic [9:0] PHASE_TICKS_RESET = 10'd10;

  // bus segment codes
  localparam logic [3:0] SEG_START = 4'd0;
  localparam logic [3:0] SEG_DEVW  = 4'd1;
  localparam logic [3:0] SEG_REG   = 4'd2;
  localparam logic [3:0] SEG_DATA  = 4'd3;
  localparam logic [3:0] SEG_DEVR  = 4'd4;
  localparam logic [3:0] SEG_ACK0  = 4'd5;
  localparam logic [3:0] SEG_ACK1  = 4'd6;
  localparam logic [3:0] SEG_ACK2  = 4'd7;
  localparam logic [3:0] SEG_RECV  = 4'd8;
  localparam logic [3:0] SEG_NACK  = 4'd9;
  localparam logic [3:0] SEG_STOP  = 4'd10;

  // segments per transaction
  localparam logic [3:0] WR_SEGS = 4'd8;
  localparam logic [3:0] RD_SEGS = 4'd11;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] reg_addr;
    logic [7:0] wr_data;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic [6:0] device_address;
    logic [9:0] phase_ticks;
  } cfg_t;

  // packed with scl_out in bit 0
  typedef struct packed {
    logic       rejected;
    logic [2:0] ack_flags;
    logic [7:0] rd_data;
    logic       done_res;
    logic       busy_res;
    logic       sda_out;
    logic       scl_out;
  } result_t;

  // phases in one segment
  function automatic logic [4:0] seg_len(input logic [3:0] code);
    logic [4:0] len;
    unique case (code)
      SEG_START:                   len = 5'd4;
      SEG_DEVW, SEG_REG,
      SEG_DATA, SEG_DEVR:          len = 5'd24;
      SEG_ACK0, SEG_ACK1, SEG_ACK2: len = 5'd4;
      SEG_RECV:                    len = 5'd25;
      SEG_NACK, SEG_STOP:          len = 5'd3;
      default:                     len = 5'd3;
    endcase
    return len;
  endfunction

  // segment at a position of the write or read sequence
  function automatic logic [3:0] seq_code(input logic rd, input logic [3:0] pos);
    logic [3:0] code;
    if (rd) begin
      unique case (pos)
        4'd0:    code = SEG_START;
        4'd1:    code = SEG_DEVW;
        4'd2:    code = SEG_ACK0;
        4'd3:    code = SEG_REG;
        4'd4:    code = SEG_ACK1;
        4'd5:    code = SEG_START;
        4'd6:    code = SEG_DEVR;
        4'd7:    code = SEG_ACK2;
        4'd8:    code = SEG_RECV;
        4'd9:    code = SEG_NACK;
        default: code = SEG_STOP;
      endcase
    end else begin
      unique case (pos)
        4'd0:    code = SEG_START;
        4'd1:    code = SEG_DEVW;
        4'd2:    code = SEG_ACK0;
        4'd3:    code = SEG_REG;
        4'd4:    code = SEG_ACK1;
        4'd5:    code = SEG_DATA;
        4'd6:    code = SEG_ACK2;
        default: code = SEG_STOP;
      endcase
    end
    return code;
  endfunction

endpackage

// ===== rtl/i2cra_seq.sv =====
// ----------------------------------------------------------------------------
// i2cra_seq
// Bit-level phase sequencer: holds the transaction state and forms the
// result of each tick.
// ----------------------------------------------------------------------------
module i2cra_seq (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  i2cra_pkg::item_t   item,
  input  i2cra_pkg::cfg_t    cfg,
  output i2cra_pkg::result_t result
);
  import i2cra_pkg::*;

  logic                        active, active_next;
  logic [3:0]                  pos, pos_next;
  logic [4:0]                  off, off_next;
  logic [1:0]                  rc, rc_next;
  logic [2:0]                  bq, bq_next;
  logic [PHASE_COUNT_BITS-1:0] tick, tick_next;
  logic                        is_read, is_read_next;
  logic [7:0]                  latched_reg, latched_reg_next;
  logic [7:0]                  latched_data, latched_data_next;
  logic [7:0]                  rshift, rshift_next;
  logic [2:0]                  ack_rec, ack_rec_next;
  logic [7:0]                  rd_hold, rd_hold_next;
  logic                        scl, scl_next;
  logic                        sda, sda_next;

  logic [CMP_W-1:0] limit, eff, tick_inc;
  logic [3:0]       cur_code, ent_code, seg_total;
  logic [7:0]       tx_byte;
  logic             enter, done, rej, is_cmd;

  always_comb begin
    limit = CMP_W'(1) << PHASE_COUNT_BITS;
    eff   = CMP_W'(cfg.phase_ticks);
    if (eff == '0) begin
      eff = CMP_W'(1);
    end
    if (eff > limit) begin
      eff = limit;
    end
    tick_inc = CMP_W'(tick) + CMP_W'(1);
    is_cmd   = (item.op == OP_WRITE) || (item.op == OP_READ);
    cur_code  = seq_code(is_read, pos);
    seg_total = is_read ? RD_SEGS : WR_SEGS;

    active_next       = active;
    pos_next          = pos;
    off_next          = off;
    rc_next           = rc;
    bq_next           = bq;
    tick_next         = tick;
    is_read_next      = is_read;
    latched_reg_next  = latched_reg;
    latched_data_next = latched_data;
    rshift_next       = rshift;
    ack_rec_next      = ack_rec;
    rd_hold_next      = rd_hold;
    scl_next          = scl;
    sda_next          = sda;
    enter             = 1'b0;
    done              = 1'b0;
    rej               = 1'b0;

    if (step) begin
      if (!active) begin
        if (is_cmd) begin
          is_read_next      = (item.op == OP_READ);
          latched_reg_next  = item.reg_addr;
          latched_data_next = item.wr_data;
          ack_rec_next      = '0;
          tick_next         = '0;
          pos_next          = '0;
          off_next          = '0;
          rc_next           = '0;
          bq_next           = '0;
          active_next       = 1'b1;
          enter             = 1'b1;
        end
      end else begin
        rej = is_cmd;
        if (tick_inc >= eff) begin
          tick_next = '0;
          if (off + 5'd1 == seg_len(cur_code)) begin
            if (pos + 4'd1 == seg_total) begin
              active_next = 1'b0;
              done        = 1'b1;
              if (is_read) begin
                rd_hold_next = rshift;
              end
            end else begin
              pos_next = pos + 4'd1;
              off_next = '0;
              rc_next  = '0;
              bq_next  = '0;
              enter    = 1'b1;
            end
          end else begin
            off_next = off + 5'd1;
            enter    = 1'b1;
            // receive segment: bit timing starts after its release phase
            if (!(cur_code == SEG_RECV && off == 5'd0)) begin
              if (rc == 2'd2) begin
                rc_next = 2'd0;
                bq_next = bq + 3'd1;
              end else begin
                rc_next = rc + 2'd1;
              end
            end
          end
        end else begin
          tick_next = tick_inc[PHASE_COUNT_BITS-1:0];
        end
      end
    end

    // pin action of the phase just entered
    ent_code = seq_code(is_read_next, pos_next);
    unique case (ent_code)
      SEG_DEVW: tx_byte = {cfg.device_address, 1'b0};
      SEG_DEVR: tx_byte = {cfg.device_address, 1'b1};
      SEG_REG:  tx_byte = latched_reg_next;
      default:  tx_byte = latched_data_next;
    endcase

    if (enter) begin
      unique case (ent_code)
        SEG_START: begin
          unique case (off_next)
            5'd0:    sda_next = 1'b1;
            5'd1:    scl_next = 1'b1;
            5'd2:    sda_next = 1'b0;
            default: scl_next = 1'b0;
          endcase
        end
        SEG_DEVW, SEG_REG, SEG_DATA, SEG_DEVR: begin
          unique case (rc_next)
            2'd0:    sda_next = tx_byte[3'd7 - bq_next];
            2'd1:    scl_next = 1'b1;
            default: scl_next = 1'b0;
          endcase
        end
        SEG_ACK0, SEG_ACK1, SEG_ACK2: begin
          unique case (off_next)
            5'd0: sda_next = 1'b1;
            5'd1: scl_next = 1'b1;
            5'd2: begin
              if (item.sda_in) begin
                unique case (ent_code)
                  SEG_ACK0: ack_rec_next[0] = 1'b1;
                  SEG_ACK1: ack_rec_next[1] = 1'b1;
                  default:  ack_rec_next[2] = 1'b1;
                endcase
              end
            end
            default: scl_next = 1'b0;
          endcase
        end
        SEG_RECV: begin
          if (off_next == 5'd0) begin
            sda_next = 1'b1;
          end else begin
            unique case (rc_next)
              2'd0:    scl_next = 1'b1;
              2'd1:    rshift_next = {rshift[6:0], item.sda_in};
              default: scl_next = 1'b0;
            endcase
          end
        end
        SEG_NACK: begin
          unique case (off_next)
            5'd0:    sda_next = 1'b1;
            5'd1:    scl_next = 1'b1;
            default: scl_next = 1'b0;
          endcase
        end
        default: begin
          unique case (off_next)
            5'd0:    sda_next = 1'b0;
            5'd1:    scl_next = 1'b1;
            default: sda_next = 1'b1;
          endcase
        end
      endcase
    end

    result.scl_out   = scl_next;
    result.sda_out   = sda_next;
    result.busy_res  = active_next;
    result.done_res  = done;
    result.rd_data   = rd_hold_next;
    result.ack_flags = ack_rec_next;
    result.rejected  = rej;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= 1'b0;
      pos          <= '0;
      off          <= '0;
      rc           <= '0;
      bq           <= '0;
      tick         <= '0;
      is_read      <= 1'b0;
      latched_reg  <= '0;
      latched_data <= '0;
      rshift       <= '0;
      ack_rec      <= '0;
      rd_hold      <= '0;
      scl          <= 1'b1;
      sda          <= 1'b1;
    end else begin
      active       <= active_next;
      pos          <= pos_next;
      off          <= off_next;
      rc           <= rc_next;
      bq           <= bq_next;
      tick         <= tick_next;
      is_read      <= is_read_next;
      latched_reg  <= latched_reg_next;
      latched_data <= latched_data_next;
      rshift       <= rshift_next;
      ack_rec      <= ack_rec_next;
      rd_hold      <= rd_hold_next;
      scl          <= scl_next;
      sda          <= sda_next;
    end
  end

endmodule

// ===== rtl/i2c_register_access_master.sv =====
// ----------------------------------------------------------------------------
// i2c_register_access_master
// I2C master for single-byte register writes and reads, stepped by ticks.
// ----------------------------------------------------------------------------
// Each input word is one tick of the bus sequencer and produces exactly one
// output word with the SCL/SDA levels to drive. With the bus idle, a tick
// whose s_tuser is a write or read command starts a transaction: a write sends
// START, device address (W), register byte, data byte and STOP; a read sends
// START, device address (W), register byte, repeated START, device address
// (R), clocks in one byte MSB first, answers NACK and sends STOP. Every pin
// step lasts phase_ticks ticks (0 acts as 1). Slave acknowledges are recorded
// in ack_flags (1 = NACK) but never alter the sequence. A command arriving
// while busy, including on the finishing tick, is dropped and flagged.
// Throughput is one word per clock: the result is formed combinationally from
// the sequencer's next state and registered, and the output register keeps
// accepting while the downstream side takes each word. m_tvalid rises in the
// cycle after accept. Configuration writes are taken at any time, ready always high.
// ----------------------------------------------------------------------------
module i2c_register_access_master (
  input  logic        clk,
  input  logic        rst,
  // input words
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // reg_addr[7:0], wr_data[15:8], sda_in[16], zero pad
  input  logic [1:0]  s_tuser,   // op
  // result words
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // scl_out[0], sda_out[1], busy_res[2], done_res[3],
                                 // rd_data[11:4], ack_flags[14:12], rejected[15]
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [9:0]  cfg_data
);
  import i2cra_pkg::*;

  cfg_t    cfg;
  item_t   item;
  result_t step_result;
  logic    step;

  assign cfg_ready = 1'b1;

  // config registers, read live by the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.device_address <= DEV_ADDR_RESET;
      cfg.phase_ticks    <= PHASE_TICKS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DEV_ADDR:    cfg.device_address <= cfg_data[6:0];
        default:         cfg.phase_ticks    <= cfg_data;
      endcase
    end
  end

  // take a word whenever the output register is free or draining this cycle
  assign s_tready = !m_tvalid || m_tready;
  assign step     = s_tvalid && s_tready;

  assign item.op       = s_tuser;
  assign item.reg_addr = s_tdata[7:0];
  assign item.wr_data  = s_tdata[15:8];
  assign item.sda_in   = s_tdata[16];

  i2cra_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (item),
    .cfg    (cfg),
    .result (step_result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      m_tdata <= step_result;
    end
  end

endmodule

// ===== rtl/i2cra_check.sv =====
// ----------------------------------------------------------------------------
// i2cra_check
// Port-level checks for the I2C register access master, bound to the top.
// ----------------------------------------------------------------------------
module i2cra_check (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  // a finishing word never reports the bus busy
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[3]) |-> !m_tdata[2])
    else $error("done with busy set");

  // a command is only rejected while a transaction runs or ends
  a_reject_busy: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[15]) |-> (m_tdata[2] || m_tdata[3]))
    else $error("reject outside a transaction");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

  // every accepted tick yields a result on the next cycle
  a_one_per_tick: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> m_tvalid)
    else $error("accepted tick without result");

endmodule

bind i2c_register_access_master i2cra_check u_i2cra_check (.*);

// ===== sim/i2c_register_access_master_tb.sv =====
// ----------------------------------------------------------------------------
// i2c_register_access_master_tb
// Self-checking bench for the tick-stepped I2C register access master.
// ----------------------------------------------------------------------------
// Every input word is one sequencer tick, and every tick returns exactly one
// result word. The bench has its own model of the bus sequencer. For each
// accepted tick, the model produces the SCL/SDA levels, the status bits,
// the received byte and the acknowledge record that are due. Result words
// are compared field by field, in order.
// A short directed table runs first at the reset device address with a zero
// phase length, which acts as one tick. After it comes random traffic at
// address 0 with two ticks per phase. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module i2c_register_access_master_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cra_pkg::*;

  // spare op code: behaves as a plain tick and is never bounced
  localparam logic [1:0] OP_SPARE = 2'd3;
  // phases in a whole write / read transfer
  localparam int WR_TOTAL = 91;
  localparam int RD_TOTAL = 123;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // reg_addr[7:0], wr_data[15:8], sda_in[16]
  logic [1:0]  s_tuser = OP_TICK;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // scl, sda, busy, done, rd_data, ack_flags, rejected
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_DEV_ADDR;
  logic [9:0]  cfg_data = '0;

  i2c_register_access_master dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // hard stop, well beyond the slowest legal run
  initial begin
    #3_000_000;
    $display("** i2c_register_access_master: FAILED **");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Bus sequencer model: its own copy of the registers and the state
  // --------------------------------------------------------------------------
  logic [6:0] dev_addr   = 7'd127;   // reset value
  logic [9:0] phase_len  = 10'd10;   // reset value
  int         phase_num  = 0;        // 0 idle, else 1-based phase
  int         tick_cnt   = 0;
  logic       rd_mode    = 1'b0;
  logic [7:0] lat_reg    = '0;
  logic [7:0] lat_data   = '0;
  logic [7:0] rx_shift   = '0;
  logic [7:0] rd_hold    = '0;
  logic [2:0] nack_bits  = '0;
  logic       scl_lvl    = 1'b1;
  logic       sda_lvl    = 1'b1;

  result_t    bus_words_due[$];

  // segment at a position of the transfer
  function automatic logic [3:0] plan_at(logic rd, int pos);
    logic [3:0] code;
    case (pos)
      0: code = SEG_START;
      1: code = SEG_DEVW;
      2: code = SEG_ACK0;
      3: code = SEG_REG;
      4: code = SEG_ACK1;
      5: code = rd ? SEG_START : SEG_DATA;
      6: code = rd ? SEG_DEVR : SEG_ACK2;
      7: code = rd ? SEG_ACK2 : SEG_STOP;
      8: code = SEG_RECV;
      9: code = SEG_NACK;
      default: code = SEG_STOP;
    endcase
    return code;
  endfunction

  function automatic int span_of(logic [3:0] code);
    int n;
    case (code)
      SEG_START, SEG_ACK0, SEG_ACK1, SEG_ACK2: n = 4;
      SEG_DEVW, SEG_REG, SEG_DATA, SEG_DEVR:   n = 24;
      SEG_RECV:                                n = 25;
      default:                                 n = 3;
    endcase
    return n;
  endfunction

  // zero phase length counts as one tick
  function automatic int ticks_per_phase();
    return (phase_len == 10'd0) ? 1 : int'(phase_len);
  endfunction

  // pin action on the first tick of the current phase
  function automatic void open_phase(logic sda);
    int         off;
    int         pos;
    int         segs;
    int         t;
    logic [3:0] code;
    logic [7:0] b;
    logic       found;
    segs  = rd_mode ? 11 : 8;
    off   = phase_num - 1;
    found = 1'b0;
    code  = SEG_STOP;
    for (pos = 0; pos < segs && !found; pos++) begin
      code = plan_at(rd_mode, pos);
      if (off < span_of(code)) found = 1'b1;
      else off -= span_of(code);
    end
    if (!found) return;
    case (code)
      SEG_START: begin
        if (off == 0) sda_lvl = 1'b1;
        else if (off == 1) scl_lvl = 1'b1;
        else if (off == 2) sda_lvl = 1'b0;
        else scl_lvl = 1'b0;
      end
      SEG_DEVW, SEG_REG, SEG_DATA, SEG_DEVR: begin
        // bytes go out MSB first: data, SCL high, SCL low per bit
        if (code == SEG_DEVW) b = {dev_addr, 1'b0};
        else if (code == SEG_DEVR) b = {dev_addr, 1'b1};
        else if (code == SEG_REG) b = lat_reg;
        else b = lat_data;
        if (off % 3 == 0) sda_lvl = b[7 - off / 3];
        else if (off % 3 == 1) scl_lvl = 1'b1;
        else scl_lvl = 1'b0;
      end
      SEG_ACK0, SEG_ACK1, SEG_ACK2: begin
        if (off == 0) sda_lvl = 1'b1;
        else if (off == 1) scl_lvl = 1'b1;
        else if (off == 2) begin
          if (sda) nack_bits[code - SEG_ACK0] = 1'b1;
        end else scl_lvl = 1'b0;
      end
      SEG_RECV: begin
        if (off == 0) sda_lvl = 1'b1;
        else begin
          t = off - 1;
          if (t % 3 == 0) scl_lvl = 1'b1;
          else if (t % 3 == 1) rx_shift = {rx_shift[6:0], sda};
          else scl_lvl = 0;
        end
      end
      SEG_NACK: begin
        if (off == 0) sda_lvl = 1'b1;
        else if (off == 1) scl_lvl = 1'b1;
        else scl_lvl = 1'b0;
      end
      default: begin  // stop
        if (off == 0) sda_lvl = 1'b0;
        else if (off == 1) scl_lvl = 1'b1;
        else sda_lvl = 1'b1;
      end
    endcase
  endfunction

  // one tick of the sequencer; returns the word it must produce
  function automatic result_t advance_bus(logic [1:0] op, logic [7:0] ra, logic [7:0] wd,
                                          logic sda);
    result_t w;
    logic    cmd;
    logic    bounced;
    logic    fin;
    cmd     = (op == OP_WRITE) || (op == OP_READ);
    bounced = 1'b0;
    fin     = 1'b0;
    if (phase_num == 0) begin
      if (cmd) begin
        rd_mode   = (op == OP_READ);
        lat_reg   = ra;
        lat_data  = wd;
        nack_bits = '0;
        tick_cnt  = 0;
        phase_num = 1;
        open_phase(sda);
      end
    end else begin
      // busy, finishing tick included
      bounced = cmd;
      if (tick_cnt + 1 >= ticks_per_phase()) begin
        tick_cnt  = 0;
        phase_num = phase_num + 1;
        if (phase_num > (rd_mode ? RD_TOTAL : WR_TOTAL)) begin
          phase_num = 0;
          fin       = 1'b1;
          if (rd_mode) rd_hold = rx_shift;
        end else begin
          open_phase(sda);
        end
      end else begin
        tick_cnt = tick_cnt + 1;
      end
    end
    w.scl_out   = scl_lvl;
    w.sda_out   = sda_lvl;
    w.busy_res  = (phase_num != 0);
    w.done_res  = fin;
    w.rd_data   = rd_hold;
    w.ack_flags = nack_bits;
    w.rejected  = bounced;
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // Stream drivers
  // --------------------------------------------------------------------------
  bit gaps_on   = 1'b1;
  bit stalls_on = 1'b1;
  int rdy_left  = 0;
  int stall_len = 0;

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // downstream ready: random bursts and stalls, held high when stalls are off
  always @(negedge clk) begin
    if (!stalls_on) begin
      m_tready <= 1'b1;
    end else if (rdy_left > 0) begin
      rdy_left = rdy_left - 1;
    end else if (m_tready) begin
      stall_len = pick_gap();
      if (stall_len > 0) begin
        m_tready <= 1'b0;
        rdy_left = stall_len - 1;
      end else begin
        rdy_left = $urandom_range(0, 7);
      end
    end else begin
      m_tready <= 1'b1;
      rdy_left = $urandom_range(0, 7);
    end
  end

  // one tick word; 'typed' pushes the literal instead of the model's word
  task automatic send_word(input logic [1:0] op, input logic [7:0] ra, input logic [7:0] wd,
                           input logic sda, input logic typed, input logic [15:0] want);
    int      gap;
    result_t w;
    gap = gaps_on ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {7'd0, sda, wd, ra};
    do @(posedge clk); while (!(s_tvalid && s_tready));
    w = advance_bus(op, ra, wd, sda);
    bus_words_due.push_back(typed ? result_t'(want) : w);
  endtask

  task automatic write_reg(input logic idx, input logic [9:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    if (idx == CFG_DEV_ADDR) dev_addr = val[6:0];
    else phase_len = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // registers change only with the bus idle and all words back
  task automatic set_config(input logic [6:0] dev, input logic [2:0] junk,
                            input logic [9:0] plen);
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (bus_words_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    write_reg(CFG_DEV_ADDR, {junk, dev});
    write_reg(CFG_PHASE_TICKS, plen);
  endtask

  // random ticks: mostly whole transfers with random SDA, some noise commands
  task automatic run_transfers(input int budget);
    int         sent;
    int         roll;
    logic [1:0] op;
    sent = 0;
    while (sent < budget) begin
      roll = $urandom_range(0, 99);
      if (phase_num == 0) begin
        if (sent == 0 || roll < 85) op = $urandom_range(0, 1) ? OP_WRITE : OP_READ;
        else op = (roll < 95) ? OP_TICK : OP_SPARE;
      end else if (phase_num == (rd_mode ? RD_TOTAL : WR_TOTAL) &&
                   tick_cnt + 1 >= ticks_per_phase() && roll < 50) begin
        // command right on the finishing tick
        op = $urandom_range(0, 1) ? OP_WRITE : OP_READ;
      end else if (roll < 4) begin
        op = $urandom_range(0, 1) ? OP_WRITE : OP_READ;
      end else begin
        op = (roll < 8) ? OP_SPARE : OP_TICK;
      end
      send_word(op, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                1'($urandom_range(0, 1)), 1'b0, '0);
      sent++;
    end
    // let the transfer in flight run out
    while (phase_num != 0)
      send_word(OP_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                1'($urandom_range(0, 1)), 1'b0, '0);
  endtask

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  int      errors     = 0;
  int      words_seen = 0;
  int      transfers  = 0;
  int      bounces    = 0;
  result_t got_w;
  result_t want_w;

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_w = result_t'(m_tdata);
      if (bus_words_due.size() == 0) begin
        $display("%0t: result word %h with nothing expected", $time, m_tdata);
        errors++;
      end else begin
        want_w = bus_words_due.pop_front();
        check_field("scl_out", want_w.scl_out, got_w.scl_out);
        check_field("sda_out", want_w.sda_out, got_w.sda_out);
        check_field("busy_res", want_w.busy_res, got_w.busy_res);
        check_field("done_res", want_w.done_res, got_w.done_res);
        check_field("rd_data", want_w.rd_data, got_w.rd_data);
        check_field("ack_flags", want_w.ack_flags, got_w.ack_flags);
        check_field("rejected", want_w.rejected, got_w.rejected);
      end
      words_seen++;
      if (got_w.done_res === 1'b1) transfers++;
      if (got_w.rejected === 1'b1) bounces++;
    end
  end

  // --------------------------------------------------------------------------
  // Directed table, run at address 127 with phase length 0 (one tick/phase).
  // A full write is 91 ticks from its command, a read 123.
  // --------------------------------------------------------------------------
  typedef struct {
    logic [1:0]  op;
    logic [7:0]  ra;
    logic [7:0]  wd;
    logic        sda;
    int          reps;
    logic        typed;
    logic [15:0] want;
  } tick_row_t;

  tick_row_t opening[13];

  initial begin
    opening = '{
      // idle after reset: both lines released, status clear
      '{OP_TICK,  8'h00, 8'h00, 1'b1, 3,   1'b1, 16'h0003},
      // unused op while idle is just a tick
      '{OP_SPARE, 8'hFF, 8'hFF, 1'b0, 1,   1'b1, 16'h0003},
      // write start: busy, START phase 0 keeps SDA high
      '{OP_WRITE, 8'hFF, 8'h00, 1'b0, 1,   1'b1, 16'h0007},
      // command while busy is bounced
      '{OP_READ,  8'h00, 8'hFF, 1'b0, 1,   1'b1, 16'h8007},
      // SDA falls with SCL high: START
      '{OP_SPARE, 8'h00, 8'h00, 1'b0, 1,   1'b1, 16'h0005},
      // run the write out with all acks low
      '{OP_TICK,  8'h00, 8'h00, 1'b0, 91,  1'b0, 16'h0000},
      // read start, SDA held high through the read
      '{OP_READ,  8'h00, 8'h00, 1'b1, 1,   1'b1, 16'h0007},
      '{OP_TICK,  8'h00, 8'h00, 1'b1, 124, 1'b0, 16'h0000},
      // all three slots NACKed, byte read as FF
      '{OP_TICK,  8'h00, 8'h00, 1'b1, 2,   1'b1, 16'h7FF3},
      // new write clears the ack record, keeps the last read byte
      '{OP_WRITE, 8'hA5, 8'hFF, 1'b1, 1,   1'b1, 16'h0FF7},
      '{OP_TICK,  8'h00, 8'h00, 1'b0, 90,  1'b0, 16'h0000},
      // command on the finishing tick: done and bounced together
      '{OP_READ,  8'h00, 8'h00, 1'b0, 1,   1'b1, 16'h8FFB},
      '{OP_TICK,  8'h00, 8'h00, 1'b0, 1,   1'b1, 16'h0FF3}
    };

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // zero phase length acts as one tick; address keeps its reset value
    write_reg(CFG_PHASE_TICKS, 10'd0);

    foreach (opening[i])
      repeat (opening[i].reps)
        send_word(opening[i].op, opening[i].ra, opening[i].wd, opening[i].sda,
                  opening[i].typed, opening[i].want);

    // random traffic at address 0 with the spare register bits set
    set_config(7'h00, 3'b111, 10'd2);
    run_transfers(150);

    // drain; the hard stop above covers a hang
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (bus_words_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Checked %0d result words: %0d finished transfers, %0d bounced commands,",
             words_seen, transfers, bounces);
    $display("phase lengths 0 (one tick) and 2, device addresses 127 and 0.");
    if (errors == 0) begin
      $display("** i2c_register_access_master: PASSED **");
    end else begin
      $display("** i2c_register_access_master: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/i2cra_pkg.sv
rtl/i2cra_seq.sv
rtl/i2c_register_access_master.sv
rtl/i2cra_check.sv
sim/i2c_register_access_master_tb.sv
